// ----- rtl/forward_query_record_table_core_assert.svh -----
// Assertion macros for the forward query record table core.
`ifndef FORWARD_QUERY_RECORD_TABLE_CORE_ASSERT_SVH
`define FORWARD_QUERY_RECORD_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define FQRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fqrt check failed");

// Next-cycle implication, disabled in reset.
`define FQRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fqrt check failed");

`endif

// ----- rtl/fqrt_pkg.sv -----
// Package: types, codes and defaults for the forward query record table.
package fqrt_pkg;
    localparam int DefTableDepth  = 256;
    localparam int DefDigestWords = 4;

    // Operation codes
    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_LOOK_ID  = 2'd1;
    localparam logic [1:0] OP_LOOK_FLG = 2'd2;
    localparam logic [1:0] OP_RELEASE  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_REFUSED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_HIT       = 3'd3;
    localparam logic [2:0] ST_MISS      = 3'd4;
    localparam logic [2:0] ST_RELEASED  = 3'd5;

    // Configuration register indexes
    localparam logic REG_TIMEOUT    = 1'b0;
    localparam logic REG_MAX_ACTIVE = 1'b1;

    localparam logic [7:0] TIMEOUT_RST    = 8'd10;
    localparam logic [8:0] MAX_ACTIVE_RST = 9'd150;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now;
        logic        force_req;
        logic [15:0] query_id;
        logic [63:0] hash_0;
        logic [63:0] hash_1;
        logic [63:0] hash_2;
        logic [63:0] hash_3;
        logic [15:0] flags;
        logic [15:0] flag_mask;
        logic [7:0]  slot;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  slot_out;
        logic        reclaimed;
        logic [15:0] entry_id;
        logic [31:0] entry_time;
    } t_rsp;

    // True when the signed wrapping difference a - b is at least lim
    function automatic logic diff_at_least(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
        logic [31:0] d;
        d = a - b;
        return !d[31] && (d >= lim);
    endfunction
endpackage

// ----- rtl/fqrt_ctrl.sv -----
// Controller: sequences accept, table scan, drain and finish.
module fqrt_ctrl #(
    parameter int TABLE_DEPTH = fqrt_pkg::DefTableDepth
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  logic       i_hit,
    output logic       o_busy,
    output logic       o_accept,
    output logic       o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    output logic       o_finish
);
    import fqrt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_LAST = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    assign o_busy    = (r_state != S_IDLE);
    assign o_accept  = i_start && !o_busy;
    assign o_rd_en   = (r_state == S_SCAN);
    assign o_rd_addr = r_idx;
    assign o_finish  = (r_state == S_FIN);

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (o_accept) begin
                    n_state = (i_op == OP_RELEASE) ? S_FIN : S_SCAN;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + 1'b1;
                if (i_hit) begin
                    n_state = S_FIN;
                end else if (r_idx == IW'(TABLE_DEPTH - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end
endmodule

// ----- rtl/fqrt_datapath.sv -----
// Datapath: record memories, status bits, scan evaluation and result.
module fqrt_datapath #(
    parameter int TABLE_DEPTH  = fqrt_pkg::DefTableDepth,
    parameter int DIGEST_WORDS = fqrt_pkg::DefDigestWords
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fqrt_pkg::t_req    i_req,
    input  logic              i_accept,
    input  logic              i_rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_rd_addr,
    input  logic              i_finish,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [8:0]        i_cfg_data,
    output logic              o_hit,
    output logic              o_done,
    output fqrt_pkg::t_rsp    o_rsp
);
    import fqrt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DB = DIGEST_WORDS * 64;

    // Record memories (payload, no reset)
    logic [31:0] m_stamp  [TABLE_DEPTH];
    logic [15:0] m_qid    [TABLE_DEPTH];
    logic [15:0] m_flags  [TABLE_DEPTH];
    logic [DB-1:0] m_dig  [TABLE_DEPTH];

    // Per-record status bits
    logic [TABLE_DEPTH-1:0] r_in_use, r_created, r_recl;

    logic [7:0]  r_timeout;
    logic [8:0]  r_max_active;
    t_req        r_req;

    // Read stage
    logic [31:0]   r_rd_stamp;
    logic [15:0]   r_rd_qid, r_rd_flags;
    logic [DB-1:0] r_rd_dig;
    logic          r_ev_valid;
    logic [IW-1:0] r_ev_idx;

    // Scan accumulators
    logic          r_tgt_found, r_old_found, r_fresh_found, r_hit;
    logic [IW-1:0] r_tgt, r_old, r_fresh, r_hit_idx;
    logic [31:0]   r_old_stamp, r_hit_stamp;
    logic [15:0]   r_hit_qid;
    logic [CW-1:0] r_count;

    logic          r_done;
    t_rsp          r_rsp;

    logic [DB-1:0] req_dig;
    logic [31:0]   lim4, lim1;
    logic          ev, ev_used, ev_created, ev_old4, ev_old1, ev_key, ev_match;
    logic          is_alloc;

    assign req_dig  = DB'({r_req.hash_3, r_req.hash_2, r_req.hash_1, r_req.hash_0});
    assign lim4     = {22'd0, r_timeout, 2'b00};
    assign lim1     = {24'd0, r_timeout};
    assign is_alloc = (r_req.op == OP_ALLOC);

    // Evaluation of the record read last cycle
    assign ev         = r_ev_valid && !r_hit;
    assign ev_used    = r_in_use[r_ev_idx];
    assign ev_created = r_created[r_ev_idx];
    assign ev_old4    = diff_at_least(r_req.now, r_rd_stamp, lim4);
    assign ev_old1    = diff_at_least(r_req.now, r_rd_stamp, lim1);
    assign ev_key     = (r_req.op == OP_LOOK_ID) ? (r_rd_qid == r_req.query_id)
                      : ((r_rd_flags & r_req.flag_mask) == r_req.flags);
    assign ev_match   = ev_used && ev_key && (r_rd_dig == req_dig);
    assign o_hit      = r_hit;

    // Finish decision for allocate
    logic          refuse, use_old, use_fresh, fin_found;
    logic [IW-1:0] fin_idx;
    logic          fin_recl;
    logic [IW+7:0] idx_ext, slot_ext;
    logic          slot_ok;
    t_rsp          n_rsp;

    always_comb begin
        slot_ext  = {{IW{1'b0}}, r_req.slot};
        slot_ok   = slot_ext < (IW + 8)'(TABLE_DEPTH);
        refuse    = !r_req.force_req && (32'(r_count) >= 32'(r_max_active));
        use_old   = !r_tgt_found && r_old_found
                    && diff_at_least(r_req.now, r_old_stamp, lim1);
        use_fresh = !r_tgt_found && !use_old && r_fresh_found;
        fin_found = r_tgt_found || use_old || use_fresh;
        fin_idx   = r_tgt_found ? r_tgt : (use_old ? r_old : r_fresh);
        fin_recl  = r_tgt_found ? r_recl[r_tgt] : use_old;
        idx_ext   = {8'd0, (r_req.op == OP_RELEASE) ? slot_ext[IW-1:0]
                           : (is_alloc ? fin_idx : r_hit_idx)};
    end

    // Result of the finishing transaction
    always_comb begin
        n_rsp = '0;
        case (r_req.op)
            OP_ALLOC: begin
                if (refuse) begin
                    n_rsp.status = ST_REFUSED;
                end else if (!fin_found) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status     = ST_ALLOCATED;
                    n_rsp.slot_out   = idx_ext[7:0];
                    n_rsp.reclaimed  = fin_recl;
                    n_rsp.entry_id   = r_req.query_id;
                    n_rsp.entry_time = r_req.now;
                end
            end
            OP_RELEASE: begin
                n_rsp.status   = ST_RELEASED;
                n_rsp.slot_out = r_req.slot;
            end
            default: begin
                if (r_hit) begin
                    n_rsp.status     = ST_HIT;
                    n_rsp.slot_out   = idx_ext[7:0];
                    n_rsp.entry_id   = r_hit_qid;
                    n_rsp.entry_time = r_hit_stamp;
                end else begin
                    n_rsp.status = ST_MISS;
                end
            end
        endcase
    end

    // Configuration registers and request latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RST;
            r_max_active <= MAX_ACTIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIMEOUT:    r_timeout    <= i_cfg_data[7:0];
                REG_MAX_ACTIVE: r_max_active <= i_cfg_data;
                default:        r_timeout    <= r_timeout;
            endcase
        end
        if (i_accept) begin
            r_req <= i_req;
        end
    end

    // Memory reads and allocate writes
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_stamp <= m_stamp[i_rd_addr];
            r_rd_qid   <= m_qid[i_rd_addr];
            r_rd_flags <= m_flags[i_rd_addr];
            r_rd_dig   <= m_dig[i_rd_addr];
        end
        if (i_finish && is_alloc && !refuse && fin_found) begin
            m_stamp[fin_idx] <= r_req.now;
            m_qid[fin_idx]   <= r_req.query_id;
            m_flags[fin_idx] <= r_req.flags;
            m_dig[fin_idx]   <= req_dig;
        end
        r_ev_idx <= i_rd_addr;
    end

    // Scan accumulators, status bits, result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use   <= '0;
            r_created  <= '0;
            r_recl     <= '0;
            r_ev_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_ev_valid <= i_rd_en;
            r_done     <= i_finish;
            if (i_accept) begin
                r_hit         <= 1'b0;
                r_tgt_found   <= 1'b0;
                r_old_found   <= 1'b0;
                r_fresh_found <= 1'b0;
                r_count       <= '0;
            end
            // alloc scan step
            if (ev && is_alloc) begin
                if (!ev_created) begin
                    if (!r_fresh_found) begin
                        r_fresh_found <= 1'b1;
                        r_fresh       <= r_ev_idx;
                    end
                end else if (!ev_used) begin
                    if (!r_tgt_found) begin
                        r_tgt_found <= 1'b1;
                        r_tgt       <= r_ev_idx;
                    end
                end else if (ev_old4) begin
                    r_in_use[r_ev_idx] <= 1'b0;
                    r_recl[r_ev_idx]   <= 1'b1;
                    if (!r_tgt_found) begin
                        r_tgt_found <= 1'b1;
                        r_tgt       <= r_ev_idx;
                    end
                end else begin
                    if (!r_old_found || r_rd_stamp - r_old_stamp >= 32'h8000_0000) begin
                        r_old_found <= 1'b1;
                        r_old       <= r_ev_idx;
                        r_old_stamp <= r_rd_stamp;
                    end
                    if (!ev_old1) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
            // lookup scan step
            if (ev && !is_alloc && ev_match) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_ev_idx;
                r_hit_qid   <= r_rd_qid;
                r_hit_stamp <= r_rd_stamp;
            end
            // finish: updates and result
            if (i_finish) begin
                r_rsp <= n_rsp;
                if (is_alloc && !refuse && fin_found) begin
                    r_in_use[fin_idx] <= 1'b1;
                    r_recl[fin_idx]   <= fin_recl;
                    if (use_fresh) begin
                        r_created[fin_idx] <= 1'b1;
                    end
                end
                if ((r_req.op == OP_RELEASE) && slot_ok) begin
                    r_in_use[slot_ext[IW-1:0]] <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;
endmodule

// ----- rtl/forward_query_record_table_core.sv -----
// Top level of the forward query record table core.
// An allocate or lookup reads one record per cycle through a single read port
// of the record memory: it holds busy through the table scan, a drain state and
// a finish state (a lookup hit ends the scan early), a release through the
// finish state only. Each result is shown on o_rsp for one cycle with o_done;
// the receiver cannot stall it, and a new start is taken while o_done is high.
// Configuration writes take effect at once and belong in idle periods.
module forward_query_record_table_core #(
    parameter int TABLE_DEPTH  = fqrt_pkg::DefTableDepth,
    parameter int DIGEST_WORDS = fqrt_pkg::DefDigestWords
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  fqrt_pkg::t_req i_req,
    output logic           o_done,
    output fqrt_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [8:0]     i_cfg_data
);
    import fqrt_pkg::*;

    logic accept, rd_en, finish, hit;
    logic [$clog2(TABLE_DEPTH)-1:0] rd_addr;

    fqrt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_op      (i_req.op),
        .i_hit     (hit),
        .o_busy    (busy),
        .o_accept  (accept),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_finish  (finish)
    );

    fqrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .DIGEST_WORDS(DIGEST_WORDS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_accept   (accept),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_finish   (finish),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_hit      (hit),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

`include "forward_query_record_table_core_assert.svh"

    `FQRT_ASSERT_NOW(a_done_idle, o_done, !busy)
    `FQRT_ASSERT_NEXT(a_accept_busy, accept, busy)
    `FQRT_ASSERT_NOW(a_status_code, o_done, o_rsp.status <= ST_RELEASED)
    `FQRT_ASSERT_NEXT(a_finish_done, finish, o_done)
endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the forward query record table core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fqrt_pkg::*;

    localparam int DEPTH      = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int HIST       = 64;

    // Predicts table responses and holds the responses still owed by the core.
    class fqrt_scoreboard;
        logic [7:0]   timeout_s;
        logic [8:0]   active_cap;
        bit           used [DEPTH];
        bit           made [DEPTH];
        bit           recl [DEPTH];
        logic [31:0]  stamp [DEPTH];
        logic [15:0]  qid [DEPTH];
        logic [15:0]  flag_bits [DEPTH];
        logic [255:0] digest [DEPTH];
        t_rsp         owed_q[$];
        int           errors;

        function void clear();
            timeout_s  = TIMEOUT_RST;
            active_cap = MAX_ACTIVE_RST;
            foreach (used[i]) begin
                used[i] = 0;
                made[i] = 0;
                recl[i] = 0;
            end
            owed_q.delete();
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [8:0] data);
            if (idx == REG_TIMEOUT) timeout_s = data[7:0];
            else active_cap = data;
        endfunction

        // signed wrapping age a - b is at least lim
        function bit aged(logic [31:0] a, logic [31:0] b, logic [31:0] lim);
            logic [31:0] d;
            d = a - b;
            return !d[31] && d >= lim;
        endfunction

        // Note an accepted request transaction and queue its response.
        function void note_request(t_req r);
            t_rsp         e;
            int           target, oldest, fresh;
            int unsigned  cnt;
            logic [255:0] key;
            bit           hit;
            e = '0;
            key = {r.hash_3, r.hash_2, r.hash_1, r.hash_0};
            case (r.op)
                OP_ALLOC: begin
                    target = -1; oldest = -1; fresh = -1; cnt = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!made[i]) begin
                            if (fresh < 0) fresh = i;
                            continue;
                        end
                        if (!used[i]) begin
                            if (target < 0) target = i;
                        end else if (aged(r.now, stamp[i], 4 * timeout_s)) begin
                            used[i] = 0;
                            flag_bits[i] = '0;
                            recl[i] = 1;
                            if (target < 0) target = i;
                        end else begin
                            logic [31:0] dd;
                            dd = stamp[i] - (oldest < 0 ? 32'd0 : stamp[oldest]);
                            if (oldest < 0 || dd[31]) oldest = i;
                        end
                        if (used[i] && !aged(r.now, stamp[i], timeout_s)) cnt++;
                    end
                    if (!r.force_req && cnt >= active_cap) begin
                        e.status = ST_REFUSED;
                    end else begin
                        if (target < 0 && oldest >= 0 &&
                            aged(r.now, stamp[oldest], timeout_s)) begin
                            target = oldest;
                            recl[target] = 1;
                        end
                        if (target < 0 && fresh >= 0) begin
                            target = fresh;
                            made[target] = 1;
                            recl[target] = 0;
                        end
                        if (target < 0) begin
                            e.status = ST_FULL;
                        end else begin
                            used[target] = 1;
                            stamp[target] = r.now;
                            qid[target] = r.query_id;
                            flag_bits[target] = r.flags;
                            digest[target] = key;
                            e.status = ST_ALLOCATED;
                            e.slot_out = target[7:0];
                            e.reclaimed = recl[target];
                            e.entry_id = r.query_id;
                            e.entry_time = r.now;
                        end
                    end
                end
                OP_LOOK_ID, OP_LOOK_FLG: begin
                    hit = 0;
                    e.status = ST_MISS;
                    for (int i = 0; i < DEPTH && !hit; i++) begin
                        if (used[i] && digest[i] == key &&
                            (r.op == OP_LOOK_ID ? qid[i] == r.query_id
                                                : (flag_bits[i] & r.flag_mask) == r.flags)) begin
                            hit = 1;
                            e.status = ST_HIT;
                            e.slot_out = i[7:0];
                            e.entry_id = qid[i];
                            e.entry_time = stamp[i];
                        end
                    end
                end
                default: begin
                    used[r.slot] = 0;
                    flag_bits[r.slot] = '0;
                    e.status = ST_RELEASED;
                    e.slot_out = r.slot;
                end
            endcase
            owed_q.push_back(e);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, exp_v, got_v);
                errors++;
            end
        endfunction

        // Check one response transaction against the oldest owed one.
        function void check_response(t_rsp got);
            t_rsp e;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected response, actual %0h", $time, got);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            report("status", e.status, got.status);
            report("slot_out", e.slot_out, got.slot_out);
            report("reclaimed", e.reclaimed, got.reclaimed);
            report("entry_id", e.entry_id, got.entry_id);
            report("entry_time", e.entry_time, got.entry_time);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_done;
    t_rsp       o_rsp;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [8:0] i_cfg_data;

    fqrt_scoreboard sb;
    int             idle_cycles;

    // recently allocated keys, reused so lookups hit
    logic [15:0]  hist_id [HIST];
    logic [15:0]  hist_flg [HIST];
    logic [255:0] hist_dig [HIST];
    int           hist_n;
    logic [31:0]  clock_s;

    forward_query_record_table_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: responses first, since a new start may be taken with o_done.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_response(o_rsp);
            if (start && !busy) sb.note_request(i_req);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Send one request; start stays high when no gap follows.
    task automatic send(t_req r, int gap);
        @(negedge i_clk);
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_req rand_req(logic [1:0] op);
        t_req r;
        r.op        = op;
        r.now       = clock_s;
        r.force_req = $urandom_range(0, 3) == 0;
        r.query_id  = 16'($urandom);
        r.hash_0    = {$urandom, $urandom};
        r.hash_1    = {$urandom, $urandom};
        r.hash_2    = {$urandom, $urandom};
        r.hash_3    = {$urandom, $urandom};
        r.flags     = 16'($urandom);
        r.flag_mask = 16'($urandom);
        r.slot      = 8'($urandom);
        return r;
    endfunction

    // Build a random request; lookups mostly reuse remembered keys.
    function automatic t_req next_req(int alloc_pct, int dt_max, bit forced);
        t_req r;
        int   p, h;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 199) == 0) clock_s = $urandom;
        else if ($urandom_range(0, 99) == 0) clock_s -= $urandom_range(1, 50);
        else clock_s += $urandom_range(0, dt_max);
        if (p < alloc_pct) r = rand_req(OP_ALLOC);
        else if (p < alloc_pct + (100 - alloc_pct) * 2 / 5) r = rand_req(OP_LOOK_ID);
        else if (p < alloc_pct + (100 - alloc_pct) * 4 / 5) r = rand_req(OP_LOOK_FLG);
        else r = rand_req(OP_RELEASE);
        if (forced) r.force_req = 1'b1;
        if (r.op == OP_ALLOC) begin
            h = hist_n % HIST;
            hist_id[h]  = r.query_id;
            hist_flg[h] = r.flags;
            hist_dig[h] = {r.hash_3, r.hash_2, r.hash_1, r.hash_0};
            hist_n++;
        end else if (r.op != OP_RELEASE && hist_n > 0 && $urandom_range(0, 9) < 8) begin
            h = $urandom_range(0, (hist_n < HIST ? hist_n : HIST) - 1);
            {r.hash_3, r.hash_2, r.hash_1, r.hash_0} = hist_dig[h];
            if (r.op == OP_LOOK_ID) r.query_id = hist_id[h];
            else r.flags = hist_flg[h] & r.flag_mask;
        end
        return r;
    endfunction

    initial begin
        t_req r;
        int   alloc_pct, dt_max;
        bit   quiet, forced;
        sb = new();
        sb.clear();
        hist_n      = 0;
        clock_s     = 32'h1000;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_TIMEOUT;
        i_cfg_data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, every operation, release of free slots
        r = rand_req(OP_ALLOC);
        r.query_id = '1; r.flags = '1; r.now = '1;
        {r.hash_3, r.hash_2, r.hash_1, r.hash_0} = '1;
        send(r, 0);
        r.op = OP_LOOK_ID; send(r, 0);
        r.op = OP_LOOK_FLG; r.flag_mask = '1; send(r, 1);
        r.query_id = '0; r.op = OP_LOOK_ID; send(r, 0);
        r = '0; r.op = OP_ALLOC; r.force_req = 1'b1; send(r, 0);
        r.op = OP_LOOK_FLG; send(r, 0);
        r.op = OP_RELEASE; r.slot = 8'd255; send(r, 0);
        r.slot = 8'd0; send(r, 0);
        r.slot = 8'd0; send(r, 2);
        r.op = OP_LOOK_ID; r.now = '1; send(r, 0);
        r = rand_req(OP_ALLOC); r.now = 32'h7fff_ffff; send(r, 0);
        r.now = 32'h8000_0000; r.query_id = 16'h1234; send(r, 0);
        r.now = 32'h8000_0028; send(r, 0);
        r.now = 32'h0; send(r, 0);
        drain();
        write_reg(REG_MAX_ACTIVE, 9'd0);
        r = rand_req(OP_ALLOC); r.force_req = 1'b0; send(r, 0);
        r.force_req = 1'b1; send(r, 0);
        drain();
        write_reg(REG_TIMEOUT, 9'h100);
        write_reg(REG_MAX_ACTIVE, 9'h1ff);
        r.now += 1; send(r, 0);
        drain();

        // Random phases over several register settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin write_reg(REG_TIMEOUT, 9'd10);  write_reg(REG_MAX_ACTIVE, 9'd150); end
                1: begin write_reg(REG_TIMEOUT, 9'd255); write_reg(REG_MAX_ACTIVE, 9'd256); end
                2: begin write_reg(REG_TIMEOUT, 9'd3);   write_reg(REG_MAX_ACTIVE, 9'd256); end
                3: begin write_reg(REG_TIMEOUT, 9'd1);   write_reg(REG_MAX_ACTIVE, 9'd1);   end
                4: begin write_reg(REG_TIMEOUT, 9'd0);   write_reg(REG_MAX_ACTIVE, 9'd20);  end
                5: begin write_reg(REG_TIMEOUT, 9'd255); write_reg(REG_MAX_ACTIVE, 9'd1);  end
                6: begin write_reg(REG_TIMEOUT, 9'd20);  write_reg(REG_MAX_ACTIVE, 9'd40); end
                7: begin write_reg(REG_TIMEOUT, 9'd6);   write_reg(REG_MAX_ACTIVE, 9'h1ff); end
                default: begin
                    write_reg(REG_TIMEOUT, 9'($urandom_range(1, 255)));
                    write_reg(REG_MAX_ACTIVE, 9'($urandom_range(1, 256)));
                end
            endcase
            // phase 1 fills the table at a standing clock to reach the full case
            alloc_pct = (ph == 1) ? 90 : 45;
            dt_max    = (ph == 1) ? 0 : (ph == 2 || ph == 7) ? 2 : 4;
            forced    = (ph == 1);
            quiet     = (ph == 3 || ph == 6);
            for (int n = 0; n < 230; n++) begin
                r = next_req(alloc_pct, dt_max, forced);
                send(r, pick_gap(quiet));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
